// ===== rtl/core/pac_pkg.sv =====
// Package for the packed array table: request kinds, status codes and the
// control structs passed between the top level, the entry cells and the result stage.
// No dependencies.
`default_nettype none

package pac_pkg;

  localparam int VAL_W  = 32;
  localparam int POS_W  = 7;
  localparam int CNT_W  = 7;
  localparam int FPOS_W = 6;
  localparam int KIND_W = 3;
  localparam int ST_W   = 2;

  // request kinds
  localparam logic [KIND_W-1:0] KIND_APPEND = 3'd0;
  localparam logic [KIND_W-1:0] KIND_INSERT = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DELETE = 3'd2;
  localparam logic [KIND_W-1:0] KIND_EDIT   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_READ   = 3'd4;
  localparam logic [KIND_W-1:0] KIND_SEARCH = 3'd5;

  // status codes
  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_BADPOS = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL   = 2'd2;

  // per-cycle update command broadcast to every cell
  typedef struct packed {
    logic             wr;      // load val into the cell at wpos
    logic             up;      // cells above wpos take their lower neighbor
    logic             down;    // cells at/above wpos take their upper neighbor
    logic [POS_W-1:0] wpos;
    logic [VAL_W-1:0] val;
  } pac_ctl_t;

  // request outcome handed to the result stage
  typedef struct packed {
    logic             vld;
    logic [ST_W-1:0]  status;
    logic             rd_ok;
    logic             srch;
    logic [CNT_W-1:0] count;
  } pac_stage_t;

endpackage

`default_nettype wire

// ===== rtl/core/packed_array_table.sv =====
// Top level of the packed array table: request decode, count and capacity
// registers, the row of entry cells and the result stage.
// Depends on pac_pkg, pac_cell and pac_result.
`default_nettype none

// Left-packed table of signed 32-bit entries held in a row of cells. A request
// is taken on any cycle with start high; busy stays low, so one request per
// cycle is sustained. At the accepting edge insert moves the cells above the
// position up by one place, delete moves those at and above it down by one,
// and search compares all cells at once. Each result is registered in stg_r,
// then in valid_r; out_valid is high for a single cycle per result. The
// receiver has no way to stall it, so it must take each result as it appears.
// Capacity writes (cfg_ready is always high) take effect for the next request.
module packed_array_table #(
  parameter int MAX_ENTRIES = 64
) (
  input  wire                              clk,
  input  wire                              rst_n,
  // request channel
  input  wire                              start,
  output logic                             busy,
  input  wire [pac_pkg::KIND_W-1:0]        in_kind,
  input  wire [pac_pkg::POS_W-1:0]         in_position,
  input  wire signed [pac_pkg::VAL_W-1:0]  in_value,
  // result channel
  output logic                             out_valid,
  output logic [pac_pkg::ST_W-1:0]         out_status,
  output logic signed [pac_pkg::VAL_W-1:0] out_read_value,
  output logic                             out_found,
  output logic [pac_pkg::FPOS_W-1:0]       out_found_position,
  output logic [pac_pkg::CNT_W-1:0]        out_entry_count,
  // capacity register write
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire [pac_pkg::CNT_W-1:0]         cfg_data
);
  import pac_pkg::*;

  logic                   accept;
  logic [CNT_W-1:0]       cap_r;
  logic [CNT_W-1:0]       count_r;
  logic [CNT_W-1:0]       count_nxt;
  logic [CNT_W-1:0]       limit;
  logic                   full;
  logic                   pos_in;    // position below count
  logic                   pos_le;    // position at or below count

  pac_ctl_t               ctl;
  pac_stage_t             stg_r;
  pac_stage_t             stg_nxt;

  logic [MAX_ENTRIES-1:0]             match_vec;
  logic [MAX_ENTRIES-1:0]             sel_vec;
  logic [MAX_ENTRIES-1:0]             match_r;
  logic [MAX_ENTRIES-1:0]             sel_r;
  logic [MAX_ENTRIES-1:0][VAL_W-1:0]  cell_vals;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start & ~busy;

  // effective limit is capacity clipped to the table size
  assign limit  = (32'(cap_r) < MAX_ENTRIES) ? cap_r : CNT_W'(MAX_ENTRIES);
  assign full   = (count_r >= limit);
  assign pos_in = (in_position <  count_r);
  assign pos_le = (in_position <= count_r);

  // request decode
  always_comb begin
    ctl            = '0;
    ctl.wpos       = in_position;
    ctl.val        = in_value;
    count_nxt      = count_r;
    stg_nxt        = '0;
    stg_nxt.vld    = accept;
    stg_nxt.status = ST_OK;
    unique case (in_kind)
      KIND_APPEND: begin
        if (full) begin
          stg_nxt.status = ST_FULL;
        end else begin
          ctl.wr    = accept;
          ctl.wpos  = count_r;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      KIND_INSERT: begin
        if (!pos_le) begin
          stg_nxt.status = ST_BADPOS;
        end else if (full) begin
          stg_nxt.status = ST_FULL;
        end else begin
          ctl.wr    = accept;
          ctl.up    = accept;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      KIND_DELETE: begin
        if (!pos_in) begin
          stg_nxt.status = ST_BADPOS;
        end else begin
          ctl.down  = accept;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      KIND_EDIT: begin
        if (!pos_in) begin
          stg_nxt.status = ST_BADPOS;
        end else begin
          ctl.wr = accept;
        end
      end
      KIND_READ: begin
        if (!pos_in) begin
          stg_nxt.status = ST_BADPOS;
        end else begin
          stg_nxt.rd_ok = 1'b1;
        end
      end
      KIND_SEARCH: begin
        stg_nxt.srch = 1'b1;
      end
      default: begin
      end
    endcase
    stg_nxt.count = count_nxt;
  end

  // control registers and request outcome
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= CNT_W'(64);
      count_r <= '0;
      stg_r   <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_data;
      end
      if (accept) begin
        count_r <= count_nxt;
      end
      stg_r <= stg_nxt;
    end
  end

  // match/select vectors taken before the update
  always_ff @(posedge clk) begin
    match_r <= match_vec;
    sel_r   <= sel_vec;
  end

  // row of entry cells
  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    logic [VAL_W-1:0] lval;
    logic [VAL_W-1:0] rval;
    if (g == 0) begin : g_lo
      assign lval = '0;
    end else begin : g_lo_n
      assign lval = cell_vals[g-1];
    end
    if (g == MAX_ENTRIES - 1) begin : g_hi
      assign rval = '0;
    end else begin : g_hi_n
      assign rval = cell_vals[g+1];
    end
    pac_cell #(
      .IDX (g)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .left_val  (lval),
      .right_val (rval),
      .pos       (in_position),
      .count     (count_r),
      .key       (in_value),
      .val       (cell_vals[g]),
      .match     (match_vec[g]),
      .sel       (sel_vec[g])
    );
  end

  pac_result #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_result (
    .clk                (clk),
    .rst_n              (rst_n),
    .stg                (stg_r),
    .match_vec          (match_r),
    .sel_vec            (sel_r),
    .cell_vals          (cell_vals),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_read_value     (out_read_value),
    .out_found          (out_found),
    .out_found_position (out_found_position),
    .out_entry_count    (out_entry_count)
  );

endmodule

`default_nettype wire

// ===== rtl/core/pac_cell.sv =====
// One entry cell of the table: holds one value and moves it to a neighbor
// on insert/delete. Also reports a search match and a read select.
// Depends on pac_pkg.
`default_nettype none

module pac_cell #(
  parameter int IDX = 0
) (
  input  wire                        clk,
  input  pac_pkg::pac_ctl_t          ctl,
  input  wire [pac_pkg::VAL_W-1:0]   left_val,
  input  wire [pac_pkg::VAL_W-1:0]   right_val,
  input  wire [pac_pkg::POS_W-1:0]   pos,
  input  wire [pac_pkg::CNT_W-1:0]   count,
  input  wire [pac_pkg::VAL_W-1:0]   key,
  output logic [pac_pkg::VAL_W-1:0]  val,
  output logic                       match,
  output logic                       sel
);
  import pac_pkg::*;

  logic [VAL_W-1:0] val_r;
  logic [VAL_W-1:0] val_nxt;
  logic             at_w;
  logic             above_w;

  assign at_w    = (32'(IDX) == 32'(ctl.wpos));
  assign above_w = (32'(IDX) >  32'(ctl.wpos));

  // next value: direct write wins, then shift from a neighbor
  always_comb begin
    val_nxt = val_r;
    if (ctl.wr && at_w) begin
      val_nxt = ctl.val;
    end else if (ctl.up && above_w) begin
      val_nxt = left_val;
    end else if (ctl.down && (above_w || at_w)) begin
      val_nxt = right_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val   = val_r;
  assign match = (val_r == key) && (32'(IDX) < 32'(count));
  assign sel   = (32'(IDX) == 32'(pos));

endmodule

`default_nettype wire

// ===== rtl/core/pac_result.sv =====
// Result stage: priority-encodes the registered match vector, picks the
// read value from the cells and drives the registered result ports.
// Depends on pac_pkg.
`default_nettype none

module pac_result #(
  parameter int MAX_ENTRIES = 64
) (
  input  wire                                         clk,
  input  wire                                         rst_n,
  input  pac_pkg::pac_stage_t                         stg,
  input  wire [MAX_ENTRIES-1:0]                       match_vec,
  input  wire [MAX_ENTRIES-1:0]                       sel_vec,
  input  wire [MAX_ENTRIES-1:0][pac_pkg::VAL_W-1:0]   cell_vals,
  output logic                                        out_valid,
  output logic [pac_pkg::ST_W-1:0]                    out_status,
  output logic signed [pac_pkg::VAL_W-1:0]            out_read_value,
  output logic                                        out_found,
  output logic [pac_pkg::FPOS_W-1:0]                  out_found_position,
  output logic [pac_pkg::CNT_W-1:0]                   out_entry_count
);
  import pac_pkg::*;

  logic                   valid_r;
  logic [ST_W-1:0]        status_r;
  logic [VAL_W-1:0]       rdata_r;
  logic                   found_r;
  logic [FPOS_W-1:0]      fpos_r;
  logic [CNT_W-1:0]       count_r;

  logic [VAL_W-1:0]       rd_mux;
  logic                   any_hit;
  logic [FPOS_W-1:0]      first_hit;

  // read select is one-hot, so an OR of gated values is the mux
  always_comb begin
    rd_mux = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      rd_mux = rd_mux | (cell_vals[i] & {VAL_W{sel_vec[i]}});
    end
  end

  // lowest matching cell; scan from the top so the lowest wins
  always_comb begin
    any_hit   = 1'b0;
    first_hit = '0;
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if (match_vec[i]) begin
        any_hit   = 1'b1;
        first_hit = FPOS_W'(i);
      end
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= stg.vld;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    status_r <= stg.status;
    rdata_r  <= stg.rd_ok ? rd_mux : '0;
    found_r  <= stg.srch & any_hit;
    fpos_r   <= (stg.srch & any_hit) ? first_hit : '0;
    count_r  <= stg.count;
  end

  assign out_valid          = valid_r;
  assign out_status         = status_r;
  assign out_read_value     = rdata_r;
  assign out_found          = found_r;
  assign out_found_position = fpos_r;
  assign out_entry_count    = count_r;

endmodule

`default_nettype wire

// ===== test/packed_array_table_tb.sv =====
// Self-checking testbench for packed_array_table: directed request table, then
// random request phases under several capacity settings, checked by a shadow table.
// Depends on pac_pkg and the packed_array_table RTL.
`timescale 1ns / 100ps

module packed_array_table_tb;
  import pac_pkg::*;

  localparam int SLOTS      = 64;
  localparam int IDLE_LIMIT = 2000;
  localparam int PHASES     = 12;
  localparam int PHASE_REQS = 152;

  // unused request kinds, expected to be ignored
  localparam logic [KIND_W-1:0] KIND_SPARE_6 = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_7 = 3'd7;

  // directed table row types
  localparam logic ROW_REQ = 1'b0;
  localparam logic ROW_CFG = 1'b1;

  // traffic mix of a random phase
  localparam int MIX_FILL  = 0;
  localparam int MIX_EVEN  = 1;
  localparam int MIX_DRAIN = 2;

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [VAL_W-1:0]  read_value;
    logic              found;
    logic [FPOS_W-1:0] found_position;
    logic [CNT_W-1:0]  entry_count;
  } table_result_t;

  typedef struct packed {
    logic              row_type;
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0]  position;
    logic [VAL_W-1:0]  value;
    logic              typed;
    table_result_t     exp;
  } dir_row_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  logic [KIND_W-1:0]       in_kind = '0;
  logic [POS_W-1:0]        in_position = '0;
  logic signed [VAL_W-1:0] in_value = '0;
  logic                    out_valid;
  logic [ST_W-1:0]         out_status;
  logic signed [VAL_W-1:0] out_read_value;
  logic                    out_found;
  logic [FPOS_W-1:0]       out_found_position;
  logic [CNT_W-1:0]        out_entry_count;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CNT_W-1:0]        cfg_data = '0;

  // shadow copy of the table, its count and the capacity register
  logic [VAL_W-1:0] shadow_entries [SLOTS];
  int               shadow_count = 0;
  int               shadow_cap = 64;

  table_result_t    pending_results [$];
  int unsigned      mismatch_count = 0;
  int unsigned      idle_cycles = 0;

  // Directed requests. Results typed in where obvious, else from the shadow table.
  dir_row_t dir_rows [29] = '{
    // empty table: every positioned access is out of range
    '{ROW_REQ, KIND_READ,   7'd0,   32'd0,        1'b1, '{ST_BADPOS, 32'd0, 1'b0, 6'd0, 7'd0}},
    '{ROW_REQ, KIND_DELETE, 7'd0,   32'd0,        1'b1, '{ST_BADPOS, 32'd0, 1'b0, 6'd0, 7'd0}},
    '{ROW_REQ, KIND_EDIT,   7'd0,   32'd5,        1'b1, '{ST_BADPOS, 32'd0, 1'b0, 6'd0, 7'd0}},
    '{ROW_REQ, KIND_INSERT, 7'd1,   32'd5,        1'b1, '{ST_BADPOS, 32'd0, 1'b0, 6'd0, 7'd0}},
    '{ROW_REQ, KIND_SEARCH, 7'd0,   32'd0,        1'b1, '{ST_OK,     32'd0, 1'b0, 6'd0, 7'd0}},
    // extremes of the value range; append ignores position
    '{ROW_REQ, KIND_APPEND, 7'h7f,  32'h7fffffff, 1'b1, '{ST_OK, 32'd0, 1'b0, 6'd0, 7'd1}},
    '{ROW_REQ, KIND_APPEND, 7'd0,   32'h80000000, 1'b1, '{ST_OK, 32'd0, 1'b0, 6'd0, 7'd2}},
    '{ROW_REQ, KIND_READ,   7'd1,   32'd0,        1'b1, '{ST_OK, 32'h80000000, 1'b0, 6'd0, 7'd2}},
    '{ROW_REQ, KIND_INSERT, 7'd0,   32'hffffffff, 1'b1, '{ST_OK, 32'd0, 1'b0, 6'd0, 7'd3}},
    // insert at count acts as append; beyond count is out of range
    '{ROW_REQ, KIND_INSERT, 7'd3,   32'd0,        1'b1, '{ST_OK,     32'd0, 1'b0, 6'd0, 7'd4}},
    '{ROW_REQ, KIND_INSERT, 7'h7f,  32'd1,        1'b1, '{ST_BADPOS, 32'd0, 1'b0, 6'd0, 7'd4}},
    '{ROW_REQ, KIND_SEARCH, 7'd0,   32'h80000000, 1'b1, '{ST_OK, 32'd0, 1'b1, 6'd2, 7'd4}},
    '{ROW_REQ, KIND_SEARCH, 7'd0,   32'd5,        1'b1, '{ST_OK, 32'd0, 1'b0, 6'd0, 7'd4}},
    '{ROW_REQ, KIND_EDIT,   7'd2,   32'h12345678, 1'b0, '0},
    '{ROW_REQ, KIND_DELETE, 7'd0,   32'd0,        1'b0, '0},
    '{ROW_REQ, KIND_READ,   7'd3,   32'd0,        1'b1, '{ST_BADPOS, 32'd0, 1'b0, 6'd0, 7'd3}},
    // unused kinds change nothing
    '{ROW_REQ, KIND_SPARE_6, 7'h55, 32'ha5a5a5a5, 1'b1, '{ST_OK, 32'd0, 1'b0, 6'd0, 7'd3}},
    '{ROW_REQ, KIND_SPARE_7, 7'h7f, 32'hffffffff, 1'b1, '{ST_OK, 32'd0, 1'b0, 6'd0, 7'd3}},
    '{ROW_REQ, KIND_READ,   7'd0,   32'd0,        1'b0, '0},
    '{ROW_REQ, KIND_DELETE, 7'd2,   32'd0,        1'b0, '0},
    '{ROW_REQ, KIND_SEARCH, 7'd0,   32'h7fffffff, 1'b0, '0},
    // zero capacity: position check still comes before the full check
    '{ROW_CFG, KIND_APPEND, 7'd0,   32'd0,        1'b0, '0},
    '{ROW_REQ, KIND_APPEND, 7'd0,   32'd1,        1'b1, '{ST_FULL,   32'd0, 1'b0, 6'd0, 7'd2}},
    '{ROW_REQ, KIND_INSERT, 7'd3,   32'd1,        1'b1, '{ST_BADPOS, 32'd0, 1'b0, 6'd0, 7'd2}},
    '{ROW_REQ, KIND_INSERT, 7'd0,   32'd1,        1'b1, '{ST_FULL,   32'd0, 1'b0, 6'd0, 7'd2}},
    // capacity lowered below the count keeps the entries
    '{ROW_CFG, KIND_APPEND, 7'd0,   32'd1,        1'b0, '0},
    '{ROW_REQ, KIND_APPEND, 7'd0,   32'd9,        1'b1, '{ST_FULL, 32'd0, 1'b0, 6'd0, 7'd2}},
    '{ROW_REQ, KIND_DELETE, 7'd1,   32'd0,        1'b0, '0},
    '{ROW_REQ, KIND_INSERT, 7'd1,   32'd9,        1'b1, '{ST_FULL, 32'd0, 1'b0, 6'd0, 7'd1}}
  };

  packed_array_table dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_kind            (in_kind),
    .in_position        (in_position),
    .in_value           (in_value),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_read_value     (out_read_value),
    .out_found          (out_found),
    .out_found_position (out_found_position),
    .out_entry_count    (out_entry_count),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_data           (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Shadow table update: applies one request and returns its result.
  function automatic table_result_t apply_request(logic [KIND_W-1:0] kind,
                                                  logic [POS_W-1:0] pos,
                                                  logic [VAL_W-1:0] val);
    table_result_t r;
    int            lim;
    int            p;
    int            i;
    r   = '0;
    lim = (shadow_cap < SLOTS) ? shadow_cap : SLOTS;
    p   = pos;
    case (kind)
      KIND_APPEND: begin
        if (shadow_count >= lim) begin
          r.status = ST_FULL;
        end else begin
          shadow_entries[shadow_count] = val;
          shadow_count++;
        end
      end
      KIND_INSERT: begin
        if (p > shadow_count) begin
          r.status = ST_BADPOS;
        end else if (shadow_count >= lim) begin
          r.status = ST_FULL;
        end else begin
          for (i = shadow_count; i > p; i--) shadow_entries[i] = shadow_entries[i-1];
          shadow_entries[p] = val;
          shadow_count++;
        end
      end
      KIND_DELETE: begin
        if (p >= shadow_count) begin
          r.status = ST_BADPOS;
        end else begin
          for (i = p; i + 1 < shadow_count; i++) shadow_entries[i] = shadow_entries[i+1];
          shadow_count--;
        end
      end
      KIND_EDIT: begin
        if (p >= shadow_count) r.status = ST_BADPOS;
        else shadow_entries[p] = val;
      end
      KIND_READ: begin
        if (p >= shadow_count) r.status = ST_BADPOS;
        else r.read_value = shadow_entries[p];
      end
      KIND_SEARCH: begin
        for (i = 0; i < shadow_count; i++) begin
          if (!r.found && shadow_entries[i] == val) begin
            r.found          = 1'b1;
            r.found_position = FPOS_W'(i);
          end
        end
      end
      default: ;
    endcase
    r.entry_count = CNT_W'(shadow_count);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [VAL_W-1:0] got, logic [VAL_W-1:0] want);
    $display("%0t ns: %s: got %h, expected %h", $time, what, got, want);
    mismatch_count++;
  endtask

  // Issue one request after a gap, wait for acceptance, record its expected result.
  task automatic send_request(logic [KIND_W-1:0] kind, logic [POS_W-1:0] pos,
                              logic [VAL_W-1:0] val, int gap, logic typed,
                              table_result_t typed_exp);
    table_result_t r;
    if (gap > 0) begin
      if (start) start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    in_kind     <= kind;
    in_position <= pos;
    in_value    <= val;
    do @(posedge clk); while (busy);
    r = apply_request(kind, pos, val);
    pending_results.push_back(typed ? typed_exp : r);
  endtask

  // Hold off new requests until every outstanding result has come back.
  task automatic drain_results();
    if (start) start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CNT_W-1:0] cap);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= cap;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    shadow_cap = cap;
  endtask

  function automatic logic [KIND_W-1:0] pick_kind(int mix);
    int r;
    int t_app;
    int t_ins;
    int t_del;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_FILL:  begin t_app = 35; t_ins = 60; t_del = 68; end
      MIX_DRAIN: begin t_app = 8;  t_ins = 16; t_del = 55; end
      default:   begin t_app = 20; t_ins = 40; t_del = 55; end
    endcase
    if (r < t_app) return KIND_APPEND;
    if (r < t_ins) return KIND_INSERT;
    if (r < t_del) return KIND_DELETE;
    r = $urandom_range(0, 99);
    if (r < 30) return KIND_EDIT;
    if (r < 60) return KIND_READ;
    if (r < 96) return KIND_SEARCH;
    return r[0] ? KIND_SPARE_7 : KIND_SPARE_6;
  endfunction

  // mostly in or just past the live range, sometimes anywhere
  function automatic logic [POS_W-1:0] pick_position();
    if ($urandom_range(0, 99) < 85) return POS_W'($urandom_range(0, shadow_count));
    return POS_W'($urandom_range(0, 127));
  endfunction

  // searches mostly hit stored values; small values make duplicates likely
  function automatic logic [VAL_W-1:0] pick_value(logic [KIND_W-1:0] kind);
    int r;
    int v;
    r = $urandom_range(0, 99);
    if (kind == KIND_SEARCH && shadow_count > 0 && r < 60)
      return shadow_entries[$urandom_range(0, shadow_count - 1)];
    r = $urandom_range(0, 99);
    if (r < 45) return $urandom;
    if (r < 80) begin
      v = $urandom_range(0, 7);
      return VAL_W'(v - 3);
    end
    case ($urandom_range(0, 3))
      0:       return 32'h7fffffff;
      1:       return 32'h80000000;
      2:       return 32'hffffffff;
      default: return 32'h00000000;
    endcase
  endfunction

  function automatic logic [CNT_W-1:0] phase_capacity(int ph);
    case (ph)
      0, 6:    return 7'd127;
      1, 5, 8: return 7'd64;
      2:       return 7'd2;
      3:       return 7'd1;
      4:       return 7'd0;
      7:       return 7'd33;
      default: return CNT_W'($urandom_range(0, 127));
    endcase
  endfunction

  // Result checker: compares each result with the oldest expectation.
  always @(posedge clk) begin
    table_result_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request pending", VAL_W'(out_status), '0);
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status)
          report_mismatch("status", VAL_W'(out_status), VAL_W'(want.status));
        if (out_read_value !== want.read_value)
          report_mismatch("read_value", out_read_value, want.read_value);
        if (out_found !== want.found)
          report_mismatch("found", VAL_W'(out_found), VAL_W'(want.found));
        if (out_found_position !== want.found_position)
          report_mismatch("found_position", VAL_W'(out_found_position),
                          VAL_W'(want.found_position));
        if (out_entry_count !== want.entry_count)
          report_mismatch("entry_count", VAL_W'(out_entry_count), VAL_W'(want.entry_count));
      end
    end
  end

  // Watchdog: any handshake or result restarts the idle count.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid === 1'b1 || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int            ph;
    int            n;
    int            mix;
    bit            no_idle;
    logic [KIND_W-1:0] k;
    table_result_t none;
    none = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed part
    foreach (dir_rows[i]) begin
      if (dir_rows[i].row_type == ROW_CFG)
        write_capacity(dir_rows[i].value[CNT_W-1:0]);
      else
        send_request(dir_rows[i].kind, dir_rows[i].position, dir_rows[i].value,
                     $urandom_range(0, 16), dir_rows[i].typed, dir_rows[i].exp);
    end

    // random phases, each under its own capacity and traffic mix
    for (ph = 0; ph < PHASES; ph++) begin
      write_capacity(phase_capacity(ph));
      no_idle = ($urandom_range(0, 2) == 0);
      mix     = ph % 3;
      for (n = 0; n < PHASE_REQS; n++) begin
        if ($urandom_range(0, 79) == 0) drain_results();
        k = pick_kind(mix);
        send_request(k, pick_position(), pick_value(k),
                     no_idle ? 0 : $urandom_range(0, 16), 1'b0, none);
      end
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
